>>> design/alp_pkg.sv
// ----------------------------------------------------------------------------
// alp_pkg: shared types and constants of the address lease pool
// Entry layout, status codes, action and outcome codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package alp_pkg;

  localparam int POOL_ENTRIES = 256;
  localparam int IDX_W        = $clog2(POOL_ENTRIES);

  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_OFFERED = 2'd1;
  localparam logic [1:0] ST_BOUND   = 2'd2;
  localparam logic [1:0] ST_SERVER  = 2'd3;

  localparam logic [2:0] ACT_OFFER   = 3'd0;
  localparam logic [2:0] ACT_REQUEST = 3'd1;
  localparam logic [2:0] ACT_RELEASE = 3'd2;
  localparam logic [2:0] ACT_TICK    = 3'd3;
  localparam logic [2:0] ACT_CLAIM   = 3'd4;

  localparam logic [1:0] OUT_OK       = 2'd0;
  localparam logic [1:0] OUT_NO_FREE  = 2'd1;
  localparam logic [1:0] OUT_NOTFOUND = 2'd2;

  localparam logic [2:0] REG_NETWORK = 3'd0;
  localparam logic [2:0] REG_COUNT   = 3'd1;
  localparam logic [2:0] REG_HOLD    = 3'd2;
  localparam logic [2:0] REG_LEASE   = 3'd3;
  localparam logic [2:0] REG_EXCL_0  = 3'd4;
  localparam logic [2:0] REG_EXCL_1  = 3'd5;
  localparam logic [2:0] REG_EXCL_2  = 3'd6;
  localparam logic [2:0] REG_EXCL_3  = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] owner;
    logic [31:0] expiry;
  } entry_t;

endpackage
`default_nettype wire

>>> design/alp_if.sv
// ----------------------------------------------------------------------------
// alp_if: handshake channels of the address lease pool
// Request, result and register write channels with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface alp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [47:0] client_mac;
  logic [31:0] requested_address;
  modport source (output valid, action, client_mac, requested_address, input ready);
  modport sink (input valid, action, client_mac, requested_address, output ready);
endinterface

interface alp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  outcome;
  logic [31:0] assigned_address;
  logic [8:0]  free_count;
  modport source (output valid, outcome, assigned_address, free_count, input ready);
  modport sink (input valid, outcome, assigned_address, free_count, output ready);
endinterface

interface alp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/alp_cell.sv
// ----------------------------------------------------------------------------
// alp_cell: one lease table entry in the rotating ring
// Takes the entry of its neighbor whenever the ring advances.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module alp_cell (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             shift,
  input  alp_pkg::entry_t d,
  output alp_pkg::entry_t q
);

  logic [1:0]  status_r;
  logic [47:0] owner_r;
  logic [31:0] expiry_r;

  // reset status only; owner and expiry of a free entry are never read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= alp_pkg::ST_FREE;
    end else if (shift) begin
      status_r <= d.status;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      owner_r  <= d.owner;
      expiry_r <= d.expiry;
    end
  end

  assign q = '{status: status_r, owner: owner_r, expiry: expiry_r};

endmodule
`default_nettype wire

>>> design/address_lease_pool.sv
// ----------------------------------------------------------------------------
// address_lease_pool: lease table for one subnet of host addresses
// Ring of entry cells rotated past one head stage that applies each action.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one request (action, client_mac, requested_address) per handshake.
//   out_ch : one result (outcome, assigned_address, free_count) per request.
//   cfg_ch : register writes (index 0..7), always ready; write only when idle.
// Timing: the result shows valid after a whole revolution of the ring
//   following acceptance. The table rotates one entry per cycle through the
//   head stage unless the ring is stalled, so a whole revolution sets the
//   time per request. One request is worked on at a time; the next can be
//   accepted in the cycle after the scan ends, while the result waits.
// Stall: if a result still waits at the last step of a scan, the ring
//   freezes until the receiver takes it.
// Reset: all entries free, time zero, registers at their defaults; the
//   block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module address_lease_pool (
  input  wire       clk,
  input  wire       rst_n,
  alp_in_if.sink    in_ch,
  alp_out_if.source out_ch,
  alp_cfg_if.sink   cfg_ch
);

  localparam int N  = alp_pkg::POOL_ENTRIES;
  localparam int IW = alp_pkg::IDX_W;

  // configuration
  logic [31:0] net_r, exc_r [4];
  logic [8:0]  cnt_r;
  logic [15:0] hold_r;
  logic [23:0] lease_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      net_r   <= '0;
      cnt_r   <= 9'd256;
      hold_r  <= 16'd60;
      lease_r <= 24'd3600;
      for (int k = 0; k < 4; k++) exc_r[k] <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        alp_pkg::REG_NETWORK: net_r   <= cfg_ch.data;
        alp_pkg::REG_COUNT:   cnt_r   <= cfg_ch.data[8:0];
        alp_pkg::REG_HOLD:    hold_r  <= cfg_ch.data[15:0];
        alp_pkg::REG_LEASE:   lease_r <= cfg_ch.data[23:0];
        default:              exc_r[cfg_ch.index[1:0]] <= cfg_ch.data;
      endcase
    end
  end
  assign cfg_ch.ready = 1'b1;

  // scan control
  logic          busy_r, found_r;
  logic [IW-1:0] idx_r;
  logic [2:0]    act_r;
  logic [47:0]   mac_r;
  logic [31:0]   off_r, time_r, asg_r;
  logic [8:0]    free_r;
  logic          out_valid_r;
  logic [1:0]    out_outcome_r;
  logic [31:0]   out_addr_r;
  logic [8:0]    out_free_r;

  logic          accept, last, step;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !busy_r;
  assign last = (idx_r == IW'(N - 1));
  assign step = busy_r && (!last || !out_valid_r || out_ch.ready);

  // ring of cells
  alp_pkg::entry_t q [N];
  alp_pkg::entry_t head_nxt;

  for (genvar k = 0; k < N; k++) begin : g_cell
    alp_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (step),
      .d     ((k == N - 1) ? head_nxt : q[(k + 1) % N]),
      .q     (q[k])
    );
  end

  // head stage: eligibility of the entry passing by and the action applied to it
  logic [8:0]  n_live;
  logic [31:0] addr;
  logic        elig, held, hit, expired;
  logic [31:0] diff;
  alp_pkg::entry_t e;

  always_comb begin
    e      = q[0];
    n_live = (cnt_r > 9'd256) ? 9'd256 : cnt_r;
    addr   = net_r + {{(32 - IW){1'b0}}, idx_r};
    elig   = (n_live >= 9'd3) && (idx_r != '0) &&
             ({{(9 - IW){1'b0}}, idx_r} <= n_live - 9'd2) &&
             (addr != exc_r[0]) && (addr != exc_r[1]) &&
             (addr != exc_r[2]) && (addr != exc_r[3]);
    held   = (e.status == alp_pkg::ST_OFFERED) || (e.status == alp_pkg::ST_BOUND);
    diff   = e.expiry - time_r;
    expired = (diff == '0) || diff[31];
    hit      = 1'b0;
    head_nxt = e;
    unique case (act_r)
      alp_pkg::ACT_OFFER: begin
        if (elig && e.status == alp_pkg::ST_FREE && !found_r) begin
          hit = 1'b1;
          head_nxt.status = alp_pkg::ST_OFFERED;
          head_nxt.owner  = mac_r;
          head_nxt.expiry = time_r + {16'd0, hold_r};
        end
      end
      alp_pkg::ACT_REQUEST: begin
        if (off_r == {{(32 - IW){1'b0}}, idx_r} && elig &&
            e.status == alp_pkg::ST_OFFERED && e.owner == mac_r) begin
          hit = 1'b1;
          head_nxt.status = alp_pkg::ST_BOUND;
          head_nxt.expiry = time_r + {8'd0, lease_r};
        end
      end
      alp_pkg::ACT_RELEASE: begin
        if (elig && held && e.owner == mac_r && !found_r) begin
          hit = 1'b1;
          head_nxt = '{status: alp_pkg::ST_FREE, owner: '0, expiry: '0};
        end
      end
      alp_pkg::ACT_TICK: begin
        if (elig && held && expired) begin
          head_nxt = '{status: alp_pkg::ST_FREE, owner: '0, expiry: '0};
        end
      end
      alp_pkg::ACT_CLAIM: begin
        if (elig && e.status == alp_pkg::ST_FREE && !found_r) begin
          hit = 1'b1;
          head_nxt = '{status: alp_pkg::ST_SERVER, owner: '0, expiry: '0};
        end
      end
      default: ;
    endcase
  end

  logic [8:0] free_nxt;
  assign free_nxt = free_r +
    9'((elig && head_nxt.status == alp_pkg::ST_FREE) ? 1 : 0);

  // final outcome of the scan
  logic        found_fin;
  logic [1:0]  outcome_fin;
  logic [31:0] asg_fin;
  always_comb begin
    found_fin = found_r || hit;
    asg_fin   = hit ? addr : asg_r;
    unique case (act_r)
      alp_pkg::ACT_OFFER, alp_pkg::ACT_CLAIM:
        outcome_fin = found_fin ? alp_pkg::OUT_OK : alp_pkg::OUT_NO_FREE;
      alp_pkg::ACT_REQUEST:
        outcome_fin = found_fin ? alp_pkg::OUT_OK : alp_pkg::OUT_NOTFOUND;
      alp_pkg::ACT_RELEASE: begin
        outcome_fin = found_fin ? alp_pkg::OUT_OK : alp_pkg::OUT_NOTFOUND;
        asg_fin     = '0;
      end
      alp_pkg::ACT_TICK: begin
        outcome_fin = alp_pkg::OUT_OK;
        asg_fin     = '0;
      end
      default: begin
        outcome_fin = alp_pkg::OUT_NOTFOUND;
        asg_fin     = '0;
      end
    endcase
    if (!found_fin) asg_fin = '0;
  end

  // scan sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      idx_r   <= '0;
      found_r <= 1'b0;
      time_r  <= '0;
    end else if (accept) begin
      busy_r  <= 1'b1;
      idx_r   <= '0;
      found_r <= 1'b0;
      if (in_ch.action == alp_pkg::ACT_TICK) time_r <= time_r + 32'd1;
    end else if (step) begin
      idx_r   <= idx_r + IW'(1);
      found_r <= found_r || hit;
      if (last) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_ch.action;
      mac_r  <= in_ch.client_mac;
      off_r  <= in_ch.requested_address - net_r;
      asg_r  <= '0;
      free_r <= '0;
    end else if (step) begin
      free_r <= free_nxt;
      if (hit) asg_r <= addr;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && last) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && last) begin
      out_outcome_r <= outcome_fin;
      out_addr_r    <= asg_fin;
      out_free_r    <= free_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.outcome          = out_outcome_r;
  assign out_ch.assigned_address = out_addr_r;
  assign out_ch.free_count       = out_free_r;

endmodule
`default_nettype wire
